// ===== hw/rtl/altitude_hold_controller_defines.svh =====
// Assertion macros for the altitude hold controller
`ifndef ALTITUDE_HOLD_CONTROLLER_DEFINES_SVH
`define ALTITUDE_HOLD_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
// ante holds -> cons holds in the same cycle
`define AHC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("altitude hold assertion failed");
// ante holds -> cons holds in the next cycle
`define AHC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("altitude hold assertion failed");
`else
`define AHC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define AHC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/ahc_pkg.sv =====
package ahc_pkg;

    localparam int IN_W       = 136;
    localparam int OUT_W      = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // shared multiplier and divider sizes
    localparam int MUL_A_W    = 20;
    localparam int MUL_B_W    = 17;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_NUM_W  = 25;
    localparam int DIV_DEN_W  = 18;

    localparam int MID_STICK       = 1500;
    localparam int HOVER_LO        = 1250;
    localparam int HOVER_HI        = 1750;
    localparam int SAFE_ALT        = 500;
    localparam int ALT_CAP         = 15000;
    localparam int CLIMB_MAX       = 350;
    localparam int LAND_CLIMB_MAX  = 250;
    localparam int LOW_CLIMB_MAX   = 83;
    localparam int VZ_MAX          = 600;
    localparam int INC_MAX         = 16384000;
    localparam int SUM_DEACT_MAX   = 8192000;
    localparam int IOUT_MAX        = 250;
    localparam int IOUT_DEACT_MAX  = 125;
    localparam int IOUT_LAND       = -185;
    localparam int STILL_VEL       = 15;
    localparam int GROUND_MS       = 100;
    localparam int LANDED_MS       = 4000;
    localparam int REACH_CM        = 50;
    localparam int THR_MARGIN      = 50;
    localparam int DESCENT_BASE    = 50;
    localparam int DESCENT_GAIN    = 200;
    localparam int SLOW_CLIMB      = 100;
    localparam int IOUT_DIVISOR    = 65535;
    localparam int THR_MAX         = 2047;

    localparam logic [7:0]  ALT_GAIN_RST    = 8'd50;
    localparam logic [7:0]  VEL_P_GAIN_RST  = 8'd100;
    localparam logic [7:0]  VEL_I_GAIN_RST  = 8'd50;
    localparam logic [7:0]  VEL_D_GAIN_RST  = 8'd10;
    localparam logic [7:0]  STICK_BAND_RST  = 8'd70;
    localparam logic [10:0] HOVER_BASE_RST  = 11'd1500;
    localparam logic [10:0] THR_FLOOR_RST   = 11'd1100;
    localparam logic [10:0] THR_CEILING_RST = 11'd1900;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALT_GAIN    = 3'd0,
        REG_VEL_P_GAIN  = 3'd1,
        REG_VEL_I_GAIN  = 3'd2,
        REG_VEL_D_GAIN  = 3'd3,
        REG_STICK_BAND  = 3'd4,
        REG_HOVER_BASE  = 3'd5,
        REG_THR_FLOOR   = 3'd6,
        REG_THR_CEILING = 3'd7
    } cfg_reg_t;

    // divider request
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

endpackage

// ===== hw/rtl/altitude_hold_controller.sv =====
// Channel   Dir  Width  Contents
// s_*       in   136    one control tick
// m_*       out  40     one result per tick
// cfg_*     in   3+11   gain and limit register writes, always ready
//
// Active tick: the GPS descent ramp also runs the divider (25 quotient bits
// at one bit a cycle). An inactive tick goes from entry straight to output.
// Every gain-register product goes through the one shared multiplier, one per cycle.
// s_tready is high only in idle; a result held on m_* does not block the
// next tick, but a finished tick waits for the output register to free.
// Reset (rst_n, asynchronous) loads register defaults and clears controller state.
`include "altitude_hold_controller_defines.svh"

module altitude_hold_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    // hold_request, land_request, armed, gps_landing, throttle_low,
    // stick_throttle[11], est_altitude[18], vert_velocity[14],
    // vert_accel[16], delta_time[16], now_ms[32], home_altitude[18], pad
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ahc_pkg::IN_W-1:0]           s_tdata,
    // active, throttle_cmd[11], takeoff_active, ground_capture,
    // ground_confirmed, landed, altitude_reached, climb_target[10],
    // integral_term[9], pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ahc_pkg::OUT_W-1:0]          m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ahc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ahc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PW = ahc_pkg::MUL_P_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ENTRY, S_LAND, S_GND, S_MODE, S_CLIMB, S_DIV, S_VZ,
        S_INC1, S_INC2, S_INTEG, S_IOUT, S_CTLP, S_THR, S_FIN
    } state_t;

    state_t state_reg;

    // configuration
    logic [7:0]  alt_gain_reg, vel_p_gain_reg, vel_i_gain_reg, vel_d_gain_reg;
    logic [7:0]  stick_band_reg;
    logic [10:0] hover_base_reg, thr_floor_reg, thr_ceiling_reg;

    // latched tick
    logic               active_reg, land_reg, gps_reg, thr_low_reg;
    logic [10:0]        stick_reg;
    logic signed [17:0] est_reg, home_reg;
    logic signed [13:0] vel_reg;
    logic signed [15:0] acc_reg;
    logic [15:0]        dt_reg;
    logic [31:0]        now_reg;

    // controller state
    logic               mode_active_reg, hovering_reg, takeoff_reg, ground_set_reg;
    logic [10:0]        hover_thr_reg;
    logic signed [17:0] target_reg;
    logic signed [9:0]  climb_reg;
    logic signed [31:0] sum_reg;
    logic signed [8:0]  iout_reg;
    logic [31:0]        land_start_reg, land_elapsed_reg;

    // working registers
    logic               capture_reg;
    logic               stick_climb_reg, land_lim_reg;
    logic signed [10:0] vz_reg;
    logic signed [15:0] pterm_reg;
    logic [10:0]        thr_reg;
    logic               m_tvalid_reg;
    logic [ahc_pkg::OUT_W-1:0] m_tdata_reg;

    // shared units
    logic signed [ahc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ahc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]               mul_p;
    ahc_pkg::div_req_t                  div_req;
    logic                               div_done;
    logic [ahc_pkg::DIV_NUM_W-1:0]      div_quo;

    function automatic logic signed [PW-1:0] trunc_shr(
        input logic signed [PW-1:0] x,
        input int unsigned          k
    );
        logic signed [PW-1:0] bias;
        begin
            bias = x[PW-1] ? ((PW'(1) <<< k) - PW'(1)) : '0;
            return (x + bias) >>> k;
        end
    endfunction

    function automatic logic signed [PW-1:0] clamp_s(
        input logic signed [PW-1:0] x,
        input logic signed [PW-1:0] lim
    );
        begin
            if (x < -lim)
                return -lim;
            else if (x > lim)
                return lim;
            else
                return x;
        end
    endfunction

    // tick decode
    logic               in_hold, in_land, in_armed;
    logic signed [18:0] tgt_err;
    logic signed [12:0] stick_diff, band_s, stick_excess;
    logic               over_band, takeoff_new, still;
    logic signed [18:0] home_off;
    logic               den_zero;
    logic [17:0]        est_off;
    logic signed [PW-1:0] land_lim;

    always_comb
    begin
        in_hold   = s_tdata[0];
        in_land   = s_tdata[1];
        in_armed  = s_tdata[2];
        tgt_err   = 19'(target_reg) - 19'(est_reg);
        stick_diff = $signed({2'b00, stick_reg}) - 13'sd1500;
        band_s     = $signed({5'b0, stick_band_reg});
        over_band  = (stick_diff > band_s) || (stick_diff < -band_s);
        stick_excess = (stick_diff > 13'sd0) ? stick_diff - band_s : stick_diff + band_s;
        if (!takeoff_reg)
            takeoff_new = thr_low_reg && ground_set_reg;
        else
            takeoff_new = !((stick_diff > band_s) &&
                            (vel_reg >= 14'(ahc_pkg::STILL_VEL)));
        still = (vel_reg < 14'(ahc_pkg::STILL_VEL)) &&
                (vel_reg > -14'(ahc_pkg::STILL_VEL));
        home_off = 19'(home_reg) - 19'(ahc_pkg::SAFE_ALT);
        den_zero = (home_off == 19'sd0);
        est_off  = 18'(19'(est_reg) - 19'(ahc_pkg::SAFE_ALT));
        land_lim = (est_reg > 18'(ahc_pkg::SAFE_ALT)) ? PW'(ahc_pkg::LAND_CLIMB_MAX)
                                                       : PW'(ahc_pkg::LOW_CLIMB_MAX);
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MODE:
            begin
                mul_b = $signed({9'b0, alt_gain_reg});
                if (land_reg)
                    mul_a = 20'(tgt_err);
                else if (takeoff_new || over_band)
                    mul_a = 20'(stick_excess);
                else if (hovering_reg)
                    mul_a = 20'(tgt_err);
            end
            S_INC1:
            begin
                mul_a = 20'(vz_reg);
                mul_b = $signed({9'b0, vel_i_gain_reg});
            end
            S_INC2:
            begin
                mul_a = mul_p[19:0];
                mul_b = $signed({1'b0, dt_reg});
            end
            S_IOUT:
            begin
                mul_a = 20'(vz_reg);
                mul_b = $signed({9'b0, vel_p_gain_reg});
            end
            S_CTLP:
            begin
                mul_a = 20'(acc_reg);
                mul_b = $signed({9'b0, vel_d_gain_reg});
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_comb
    begin
        div_req.start = (state_reg == S_MODE) && land_reg && gps_reg &&
                        (est_reg > 18'(ahc_pkg::SAFE_ALT)) && !den_zero;
        div_req.num   = ahc_pkg::DIV_NUM_W'(est_off) * ahc_pkg::DIV_NUM_W'(ahc_pkg::DESCENT_GAIN);
        div_req.den   = home_off[18] ? 18'(-home_off) : home_off[17:0];
    end

    ahc_mul #(
        .A_W(ahc_pkg::MUL_A_W),
        .B_W(ahc_pkg::MUL_B_W)
    ) u_mul (
        .clk(clk),
        .a  (mul_a),
        .b  (mul_b),
        .p  (mul_p)
    );

    ahc_div #(
        .NUM_W(ahc_pkg::DIV_NUM_W),
        .DEN_W(ahc_pkg::DIV_DEN_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .done (div_done),
        .quo  (div_quo)
    );

    // per-state arithmetic
    logic signed [PW-1:0] climb_calc, descent_calc, inc_calc, dterm, thr_calc;
    logic signed [PW-1:0] vz_calc, lo_lim, hi_lim;
    logic signed [32:0]   sum_calc;
    logic [31:0]          sum_mag;
    logic [15:0]          q0;
    logic [16:0]          r0;
    logic [16:0]          q_mag;
    logic [8:0]           q_clip;
    logic signed [18:0]   reach_err;

    always_comb
    begin
        if (stick_climb_reg)
            climb_calc = clamp_s(trunc_shr(mul_p, 2), PW'(ahc_pkg::CLIMB_MAX));
        else if (land_lim_reg)
            climb_calc = clamp_s(trunc_shr(mul_p, 1), land_lim);
        else
            climb_calc = clamp_s(trunc_shr(mul_p, 1), PW'(ahc_pkg::CLIMB_MAX));

        descent_calc = home_off[18] ? PW'(div_quo) - PW'(ahc_pkg::DESCENT_BASE)
                                    : -(PW'(div_quo) + PW'(ahc_pkg::DESCENT_BASE));
        descent_calc = clamp_s(descent_calc, PW'(ahc_pkg::CLIMB_MAX));

        vz_calc = clamp_s(PW'(climb_reg) - PW'(vel_reg), PW'(ahc_pkg::VZ_MAX));

        inc_calc = trunc_shr(mul_p, 7);
        if (hovering_reg && (climb_reg < 10'(ahc_pkg::SLOW_CLIMB)) &&
            (climb_reg > -10'(ahc_pkg::SLOW_CLIMB)))
            inc_calc = trunc_shr(inc_calc, 1);
        inc_calc = clamp_s(inc_calc, PW'(ahc_pkg::INC_MAX));
        sum_calc = 33'(sum_reg) + 33'(inc_calc);
        if (sum_calc > 33'sh0_7FFF_FFFF)
            sum_calc = 33'sh0_7FFF_FFFF;
        else if (sum_calc < -33'sh0_8000_0000)
            sum_calc = -33'sh0_8000_0000;

        // |sum| / 65535 as shift plus one correction
        sum_mag = sum_reg[31] ? 32'(-33'(sum_reg)) : 32'(sum_reg);
        q0      = sum_mag[31:16];
        r0      = {1'b0, sum_mag[15:0]} + {1'b0, q0};
        q_mag   = {1'b0, q0} + ((r0 >= 17'(ahc_pkg::IOUT_DIVISOR)) ? 17'd1 : 17'd0);
        q_clip  = (q_mag > 17'(ahc_pkg::IOUT_MAX)) ? 9'(ahc_pkg::IOUT_MAX) : q_mag[8:0];

        dterm    = trunc_shr(mul_p, 6);
        thr_calc = PW'({1'b0, hover_thr_reg}) + PW'(pterm_reg) + PW'(iout_reg) - dterm;
        lo_lim   = PW'({1'b0, thr_floor_reg}) + PW'(ahc_pkg::THR_MARGIN);
        hi_lim   = PW'({1'b0, thr_ceiling_reg}) - PW'(ahc_pkg::THR_MARGIN);
        if (thr_calc < lo_lim)
            thr_calc = lo_lim;
        else if (thr_calc > hi_lim)
            thr_calc = hi_lim;
        if (thr_calc < 0)
            thr_calc = '0;
        else if (thr_calc > PW'(ahc_pkg::THR_MAX))
            thr_calc = PW'(ahc_pkg::THR_MAX);

        reach_err = 19'(target_reg) - 19'(est_reg);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_gain_reg    <= ahc_pkg::ALT_GAIN_RST;
            vel_p_gain_reg  <= ahc_pkg::VEL_P_GAIN_RST;
            vel_i_gain_reg  <= ahc_pkg::VEL_I_GAIN_RST;
            vel_d_gain_reg  <= ahc_pkg::VEL_D_GAIN_RST;
            stick_band_reg  <= ahc_pkg::STICK_BAND_RST;
            hover_base_reg  <= ahc_pkg::HOVER_BASE_RST;
            thr_floor_reg   <= ahc_pkg::THR_FLOOR_RST;
            thr_ceiling_reg <= ahc_pkg::THR_CEILING_RST;
        end
        else if (cfg_valid)
        begin
            unique case (ahc_pkg::cfg_reg_t'(cfg_index))
                ahc_pkg::REG_ALT_GAIN:    alt_gain_reg    <= cfg_data[7:0];
                ahc_pkg::REG_VEL_P_GAIN:  vel_p_gain_reg  <= cfg_data[7:0];
                ahc_pkg::REG_VEL_I_GAIN:  vel_i_gain_reg  <= cfg_data[7:0];
                ahc_pkg::REG_VEL_D_GAIN:  vel_d_gain_reg  <= cfg_data[7:0];
                ahc_pkg::REG_STICK_BAND:  stick_band_reg  <= cfg_data[7:0];
                ahc_pkg::REG_HOVER_BASE:  hover_base_reg  <= cfg_data;
                ahc_pkg::REG_THR_FLOOR:   thr_floor_reg   <= cfg_data;
                ahc_pkg::REG_THR_CEILING: thr_ceiling_reg <= cfg_data;
                default:                  alt_gain_reg    <= alt_gain_reg;
            endcase
        end
    end

    // tick payload latch
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            land_reg    <= in_land;
            gps_reg     <= s_tdata[3];
            thr_low_reg <= s_tdata[4];
            stick_reg   <= s_tdata[15:5];
            est_reg     <= s_tdata[33:16];
            vel_reg     <= s_tdata[47:34];
            acc_reg     <= s_tdata[63:48];
            dt_reg      <= s_tdata[79:64];
            now_reg     <= s_tdata[111:80];
            home_reg    <= s_tdata[129:112];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            active_reg       <= 1'b0;
            mode_active_reg  <= 1'b0;
            hovering_reg     <= 1'b0;
            takeoff_reg      <= 1'b0;
            ground_set_reg   <= 1'b0;
            hover_thr_reg    <= '0;
            target_reg       <= '0;
            climb_reg        <= '0;
            sum_reg          <= '0;
            iout_reg         <= '0;
            land_start_reg   <= '0;
            land_elapsed_reg <= '0;
            capture_reg      <= 1'b0;
            stick_climb_reg  <= 1'b0;
            land_lim_reg     <= 1'b0;
            vz_reg           <= '0;
            pterm_reg        <= '0;
            thr_reg          <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        active_reg  <= (in_hold || in_land) && in_armed;
                        capture_reg <= 1'b0;
                        thr_reg     <= '0;
                        state_reg   <= S_ENTRY;
                    end
                end
                S_ENTRY:
                begin
                    if (active_reg)
                    begin
                        if (!mode_active_reg)
                        begin
                            mode_active_reg <= 1'b1;
                            hovering_reg    <= 1'b0;
                            takeoff_reg     <= 1'b0;
                            if (hover_thr_reg < 11'(ahc_pkg::HOVER_LO) ||
                                hover_thr_reg > 11'(ahc_pkg::HOVER_HI))
                            begin
                                if (hover_base_reg < 11'(ahc_pkg::HOVER_LO))
                                    hover_thr_reg <= 11'(ahc_pkg::HOVER_LO);
                                else if (hover_base_reg > 11'(ahc_pkg::HOVER_HI))
                                    hover_thr_reg <= 11'(ahc_pkg::HOVER_HI);
                                else
                                    hover_thr_reg <= hover_base_reg;
                            end
                            land_start_reg   <= now_reg;
                            land_elapsed_reg <= '0;
                            ground_set_reg   <= 1'b0;
                        end
                        state_reg <= S_LAND;
                    end
                    else
                    begin
                        // falling out of hold: relax integrator, reset detector
                        if (mode_active_reg)
                        begin
                            mode_active_reg <= 1'b0;
                            takeoff_reg     <= 1'b0;
                            climb_reg       <= '0;
                            sum_reg  <= 32'(clamp_s(PW'(sum_reg), PW'(ahc_pkg::SUM_DEACT_MAX)));
                            iout_reg <= 9'(clamp_s(PW'(iout_reg), PW'(ahc_pkg::IOUT_DEACT_MAX)));
                            land_start_reg   <= now_reg;
                            land_elapsed_reg <= '0;
                            ground_set_reg   <= 1'b0;
                        end
                        state_reg <= S_FIN;
                    end
                end
                S_LAND:
                begin
                    if (still && iout_reg <= 9'(ahc_pkg::IOUT_LAND) &&
                        est_reg < 18'(ahc_pkg::SAFE_ALT))
                        land_elapsed_reg <= now_reg - land_start_reg;
                    else
                    begin
                        land_start_reg   <= now_reg;
                        land_elapsed_reg <= '0;
                        ground_set_reg   <= 1'b0;
                    end
                    state_reg <= S_GND;
                end
                S_GND:
                begin
                    if (!ground_set_reg && land_elapsed_reg >= 32'(ahc_pkg::GROUND_MS))
                    begin
                        ground_set_reg <= 1'b1;
                        capture_reg    <= 1'b1;
                    end
                    state_reg <= S_MODE;
                end
                S_MODE:
                begin
                    if (land_reg)
                    begin
                        takeoff_reg <= 1'b0;
                        if (gps_reg)
                        begin
                            hovering_reg <= 1'b0;
                            target_reg <= (est_reg > 18'(ahc_pkg::ALT_CAP)) ?
                                          18'(ahc_pkg::ALT_CAP) : est_reg;
                            if (est_reg > 18'(ahc_pkg::SAFE_ALT))
                            begin
                                if (den_zero)
                                begin
                                    climb_reg <= -10'(ahc_pkg::DESCENT_BASE);
                                    state_reg <= S_VZ;
                                end
                                else
                                    state_reg <= S_DIV;
                            end
                            else
                            begin
                                // low descent: stored rate flips each tick
                                climb_reg <= -climb_reg;
                                state_reg <= S_VZ;
                            end
                        end
                        else
                        begin
                            hovering_reg    <= 1'b1;
                            stick_climb_reg <= 1'b0;
                            land_lim_reg    <= 1'b1;
                            state_reg       <= S_CLIMB;
                        end
                    end
                    else
                    begin
                        takeoff_reg <= takeoff_new;
                        if (takeoff_new || over_band)
                        begin
                            hovering_reg <= 1'b0;
                            if (!over_band)
                            begin
                                climb_reg <= '0;
                                state_reg <= S_VZ;
                            end
                            else
                            begin
                                stick_climb_reg <= 1'b1;
                                land_lim_reg    <= 1'b0;
                                state_reg       <= S_CLIMB;
                            end
                        end
                        else
                        begin
                            if (!hovering_reg)
                            begin
                                hovering_reg <= 1'b1;
                                target_reg   <= est_reg;
                            end
                            stick_climb_reg <= 1'b0;
                            land_lim_reg    <= 1'b0;
                            state_reg       <= S_CLIMB;
                        end
                    end
                end
                S_CLIMB:
                begin
                    climb_reg <= climb_calc[9:0];
                    state_reg <= S_VZ;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        climb_reg <= descent_calc[9:0];
                        state_reg <= S_VZ;
                    end
                end
                S_VZ:
                begin
                    vz_reg    <= vz_calc[10:0];
                    state_reg <= S_INC1;
                end
                S_INC1:
                    state_reg <= S_INC2;
                S_INC2:
                    state_reg <= S_INTEG;
                S_INTEG:
                begin
                    sum_reg   <= sum_calc[31:0];
                    state_reg <= S_IOUT;
                end
                S_IOUT:
                begin
                    iout_reg  <= sum_reg[31] ? -$signed(q_clip) : $signed(q_clip);
                    state_reg <= S_CTLP;
                end
                S_CTLP:
                begin
                    pterm_reg <= 16'(trunc_shr(mul_p, 5));
                    state_reg <= S_THR;
                end
                S_THR:
                begin
                    thr_reg   <= thr_calc[10:0];
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'b0, iout_reg, climb_reg,
                                         (reach_err < 19'(ahc_pkg::REACH_CM)) &&
                                         (reach_err > -19'(ahc_pkg::REACH_CM)),
                                         ground_set_reg &&
                                         (land_elapsed_reg >= 32'(ahc_pkg::LANDED_MS)),
                                         ground_set_reg, capture_reg, takeoff_reg,
                                         thr_reg, active_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // a capture pulse only comes with the ground latch set
    `AHC_ASSERT_IMP(a_capture_grounded, clk, rst_n, m_tvalid && m_tdata[13], m_tdata[14])
    // an inactive tick carries no throttle
    `AHC_ASSERT_IMP(a_idle_throttle, clk, rst_n, m_tvalid && !m_tdata[0], m_tdata[11:1] == 11'd0)
    // divider finishes only while the sequencer waits for it
    `AHC_ASSERT_IMP(a_div_in_wait, clk, rst_n, div_done, state_reg == S_DIV)
    // one tick at a time
    `AHC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

// ===== hw/rtl/ahc_mul.sv =====
// Shared signed multiplier, product registered
module ahc_mul #(
    parameter int A_W = ahc_pkg::MUL_A_W,
    parameter int B_W = ahc_pkg::MUL_B_W
) (
    input  logic                   clk,
    input  logic signed [A_W-1:0]  a,
    input  logic signed [B_W-1:0]  b,
    output logic signed [A_W+B_W-1:0] p
);

    logic signed [A_W+B_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/ahc_div.sv =====
// Unsigned restoring divider, one quotient bit a cycle
module ahc_div #(
    parameter int NUM_W = ahc_pkg::DIV_NUM_W,
    parameter int DEN_W = ahc_pkg::DIV_DEN_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ahc_pkg::div_req_t req,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            den_reg <= req.den;
            quo_reg <= req.num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ahc_pkg::*;

    localparam int  CLK_HALF    = 4;
    localparam int  RST_CYCLES  = 10;
    localparam int  SEG_ITEMS   = 305;   // six random segments, ~1830 items
    localparam int  DRAIN_WAIT  = 60;
    localparam longint CYCLE_LIMIT = 2000000;

    // One control tick, packed to match s_tdata from bit 0 upward
    typedef struct packed {
        logic [17:0] home;
        logic [31:0] now;
        logic [15:0] dt;
        logic [15:0] acc;
        logic [13:0] vel;
        logic [17:0] est;
        logic [10:0] stick;
        logic        thr_low;
        logic        gps;
        logic        armed;
        logic        land;
        logic        hold;
    } tick_t;

    // One result, packed to match m_tdata from bit 0 upward
    typedef struct packed {
        logic [8:0]  iout;
        logic [9:0]  climb;
        logic        reached;
        logic        landed;
        logic        confirmed;
        logic        capture;
        logic        takeoff;
        logic [10:0] thr;
        logic        active;
    } res_t;

    typedef struct {
        tick_t t;
        bit    lit;      // expected result typed into the table
        res_t  r;
    } row_t;

    // flight profiles for the random part
    typedef enum int {FL_SIT, FL_CLIMB, FL_HOVER, FL_GPS, FL_LANDHOLD, FL_NOISE} flight_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    altitude_hold_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Controller model: own copy of registers and state
    // ------------------------------------------------------------------
    longint k_alt, k_p, k_i, k_d, band_w, hover_base_w, floor_w, ceil_w;
    bit     in_mode, hover_on, takeoff_on, ground_on;
    longint hover_thr, alt_target, climb_rate, i_sum, i_out;
    logic [31:0] land_t0, land_dt;

    res_t   pending_res[$];   // results still owed by the block
    int     fails = 0;
    int     snd_idle_pct = 0;
    int     rcv_idle_pct = 0;
    longint cycles = 0;

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void land_clear(logic [31:0] now);
        land_t0   = now;
        land_dt   = '0;
        ground_on = 1'b0;
    endfunction

    function automatic void model_reset();
        k_alt = ALT_GAIN_RST;     k_p = VEL_P_GAIN_RST;
        k_i = VEL_I_GAIN_RST;     k_d = VEL_D_GAIN_RST;
        band_w = STICK_BAND_RST;  hover_base_w = HOVER_BASE_RST;
        floor_w = THR_FLOOR_RST;  ceil_w = THR_CEILING_RST;
        in_mode = 0; hover_on = 0; takeoff_on = 0; ground_on = 0;
        hover_thr = 0; alt_target = 0; climb_rate = 0; i_sum = 0; i_out = 0;
        land_t0 = '0; land_dt = '0;
    endfunction

    function automatic void model_write(cfg_reg_t idx, logic [10:0] v);
        case (idx)
            REG_ALT_GAIN:    k_alt = v[7:0];
            REG_VEL_P_GAIN:  k_p = v[7:0];
            REG_VEL_I_GAIN:  k_i = v[7:0];
            REG_VEL_D_GAIN:  k_d = v[7:0];
            REG_STICK_BAND:  band_w = v[7:0];
            REG_HOVER_BASE:  hover_base_w = v;
            REG_THR_FLOOR:   floor_w = v;
            REG_THR_CEILING: ceil_w = v;
            default: ;
        endcase
    endfunction

    // Advances the model by one tick and returns the result it owes
    function automatic res_t tick_response(tick_t t);
        longint est, vel, acc, dt, home, stick, diff, dv, q, vz, inc, ctl, lo, hi, thr;
        bit     act, cap;
        res_t   r;
        est = $signed(t.est);
        vel = $signed(t.vel);
        acc = $signed(t.acc);
        home = $signed(t.home);
        dt = t.dt;
        stick = t.stick;
        act = (t.hold || t.land) && t.armed;
        cap = 0;
        thr = 0;
        if (act) begin
            if (!in_mode) begin
                in_mode = 1; hover_on = 0; takeoff_on = 0;
                if (hover_thr < HOVER_LO || hover_thr > HOVER_HI)
                    hover_thr = clip(hover_base_w, HOVER_LO, HOVER_HI);
                land_clear(t.now);
            end
            // still on the ground: keep timing, else restart the timer
            if (mag(vel) < STILL_VEL && i_out <= IOUT_LAND && est < SAFE_ALT)
                land_dt = t.now - land_t0;
            else
                land_clear(t.now);
            if (!ground_on && land_dt >= GROUND_MS) begin
                ground_on = 1;
                cap = 1;
            end
            if (t.land) begin
                takeoff_on = 0;
                if (t.gps) begin
                    hover_on = 0;
                    alt_target = est > ALT_CAP ? ALT_CAP : est;
                    if (est > SAFE_ALT) begin
                        dv = home - SAFE_ALT;
                        q = dv != 0 ? (DESCENT_GAIN * (est - SAFE_ALT)) / dv : 0;
                        climb_rate = DESCENT_BASE + q;
                    end
                    climb_rate = -climb_rate;
                end else begin
                    hover_on = 1;
                    climb_rate = ((alt_target - est) * k_alt) / 2;
                    if (est > SAFE_ALT)
                        climb_rate = clip(climb_rate, -LAND_CLIMB_MAX, LAND_CLIMB_MAX);
                    else
                        climb_rate = clip(climb_rate, -LOW_CLIMB_MAX, LOW_CLIMB_MAX);
                end
            end else begin
                diff = stick - MID_STICK;
                if (!takeoff_on) begin
                    if (t.thr_low && ground_on)
                        takeoff_on = 1;
                end else if (diff > band_w && vel >= STILL_VEL) begin
                    takeoff_on = 0;
                end
                if (takeoff_on || mag(diff) > band_w) begin
                    hover_on = 0;
                    if (mag(diff) <= band_w)
                        climb_rate = 0;
                    else
                        climb_rate = ((diff - (diff > 0 ? band_w : -band_w)) * k_alt) / 4;
                end else begin
                    if (!hover_on) begin
                        hover_on = 1;
                        alt_target = est;
                    end
                    climb_rate = ((alt_target - est) * k_alt) / 2;
                end
            end
            climb_rate = clip(climb_rate, -CLIMB_MAX, CLIMB_MAX);
            vz = clip(climb_rate - vel, -VZ_MAX, VZ_MAX);
            inc = (vz * k_i * dt) / 128;
            if (hover_on && mag(climb_rate) < SLOW_CLIMB)
                inc = inc / 2;
            inc = clip(inc, -INC_MAX, INC_MAX);
            i_sum = clip(i_sum + inc, -64'sd2147483648, 64'sd2147483647);
            i_out = clip(i_sum / IOUT_DIVISOR, -IOUT_MAX, IOUT_MAX);
            ctl = (vz * k_p) / 32 + i_out - (acc * k_d) / 64;
            lo = floor_w + THR_MARGIN;
            hi = ceil_w - THR_MARGIN;
            thr = hover_thr + ctl;
            // when the limits cross, a value below the floor takes the floor, any other the ceiling
            if (thr < lo) thr = lo;
            else if (thr > hi) thr = hi;
            thr = clip(thr, 0, THR_MAX);
        end else if (in_mode) begin
            in_mode = 0; takeoff_on = 0; climb_rate = 0;
            i_sum = clip(i_sum, -SUM_DEACT_MAX, SUM_DEACT_MAX);
            i_out = clip(i_out, -IOUT_DEACT_MAX, IOUT_DEACT_MAX);
            land_clear(t.now);
        end
        r.active    = act;
        r.thr       = thr[10:0];
        r.takeoff   = takeoff_on;
        r.capture   = cap;
        r.confirmed = ground_on;
        r.landed    = ground_on && land_dt >= LANDED_MS;
        r.reached   = mag(alt_target - est) < REACH_CM;
        r.climb     = climb_rate[9:0];
        r.iout      = i_out[8:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and field-by-field compare
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        res_t got, want;
        if (m_tvalid && m_tready) begin
            got = res_t'(m_tdata[$bits(res_t)-1:0]);
            if (pending_res.size() == 0) begin
                $error("result item with nothing expected: %h", m_tdata);
                fails++;
            end else begin
                want = pending_res.pop_front();
                if (got.active !== want.active) begin
                    $error("active: expected %0d got %0d", want.active, got.active); fails++;
                end
                if (got.thr !== want.thr) begin
                    $error("throttle_cmd: expected %0d got %0d", want.thr, got.thr); fails++;
                end
                if (got.takeoff !== want.takeoff) begin
                    $error("takeoff_active: expected %0d got %0d", want.takeoff, got.takeoff);
                    fails++;
                end
                if (got.capture !== want.capture) begin
                    $error("ground_capture: expected %0d got %0d", want.capture, got.capture);
                    fails++;
                end
                if (got.confirmed !== want.confirmed) begin
                    $error("ground_confirmed: expected %0d got %0d",
                           want.confirmed, got.confirmed);
                    fails++;
                end
                if (got.landed !== want.landed) begin
                    $error("landed: expected %0d got %0d", want.landed, got.landed); fails++;
                end
                if (got.reached !== want.reached) begin
                    $error("altitude_reached: expected %0d got %0d", want.reached, got.reached);
                    fails++;
                end
                if (got.climb !== want.climb) begin
                    $error("climb_target: expected %0d got %0d",
                           $signed(want.climb), $signed(got.climb));
                    fails++;
                end
                if (got.iout !== want.iout) begin
                    $error("integral_term: expected %0d got %0d",
                           $signed(want.iout), $signed(got.iout));
                    fails++;
                end
            end
        end
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // one tick through the slave port; the model runs at the accepting edge
    task automatic send_tick(tick_t t, bit lit, res_t lit_res);
        res_t r;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - $bits(tick_t)){1'b0}}, t};
        do @(posedge clk); while (!s_tready);
        r = tick_response(t);
        pending_res.push_back(lit ? lit_res : r);
    endtask

    // hold off until every owed result is back; registers are written only after a drain
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
    endtask

    task automatic reg_write(cfg_reg_t idx, logic [10:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_write(idx, v);
    endtask

    task automatic reg_write_all(int g0, int g1, int g2, int g3, int g4,
                                 int hb, int fl, int cl);
        reg_write(REG_ALT_GAIN, g0);
        reg_write(REG_VEL_P_GAIN, g1);
        reg_write(REG_VEL_I_GAIN, g2);
        reg_write(REG_VEL_D_GAIN, g3);
        reg_write(REG_STICK_BAND, g4);
        reg_write(REG_HOVER_BASE, hb);
        reg_write(REG_THR_FLOOR, fl);
        reg_write(REG_THR_CEILING, cl);
    endtask

    function automatic tick_t mk_tick(bit hold, bit land, bit armed, bit gps, bit tl,
                                      int stick, int est, int vel, int acc, int dt,
                                      logic [31:0] now, int home);
        tick_t t;
        t.hold = hold; t.land = land; t.armed = armed; t.gps = gps; t.thr_low = tl;
        t.stick = stick; t.est = est; t.vel = vel; t.acc = acc; t.dt = dt;
        t.now = now; t.home = home;
        return t;
    endfunction

    function automatic int srange(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        row_t        rows[$];
        row_t        rw;
        res_t        zero_res;
        tick_t       t;
        flight_t     prof;
        int          prof_left;
        int          seg, n, i;
        int          est_c;
        logic [31:0] clock_ms;

        model_reset();
        zero_res = '0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed table, reset register values ---
        // idle after reset, craft on the reference level: nothing but "reached"
        rw.t = mk_tick(0, 0, 0, 0, 0, 1000, 0, 0, 0, 0, 0, 0);
        rw.lit = 1; rw.r = zero_res; rw.r.reached = 1; rows.push_back(rw);
        // hold asked but disarmed, every field at its far end
        rw.t = mk_tick(1, 1, 0, 1, 1, 2000, 100000, -5000, -32768, 65535,
                       32'hFFFF_FFFF, -100000);
        rw.lit = 1; rw.r = zero_res; rows.push_back(rw);
        rw.lit = 0;
        // engage hold at centre stick, then stick extremes
        rw.t = mk_tick(1, 0, 1, 0, 0, 1500, 0, 0, 0, 20000, 0, 0); rows.push_back(rw);
        rw.t = mk_tick(1, 0, 1, 0, 0, 2000, 100000, 5000, 32767, 65535, 20, 100000);
        rows.push_back(rw);
        rw.t = mk_tick(1, 0, 1, 0, 0, 1000, -100000, -5000, -32768, 65535, 40, 0);
        rows.push_back(rw);
        // sink the integrator on the ground, then sit still until ground latches
        for (i = 0; i < 3; i++) begin
            rw.t = mk_tick(1, 0, 1, 0, 1, 1000, 0, 0, 0, 65535, 60 + 20 * i, 0);
            rows.push_back(rw);
        end
        for (i = 0; i < 8; i++) begin
            rw.t = mk_tick(1, 0, 1, 0, 1, 1500, 0, 0, 0, 20000, 120 + 20 * i, 0);
            rows.push_back(rw);
        end
        // takeoff ends on a firm climb
        rw.t = mk_tick(1, 0, 1, 0, 0, 1800, 100, 20, 0, 20000, 300, 0); rows.push_back(rw);
        // GPS descent: zero divisor, above the altitude cap, low descent re-negation
        rw.t = mk_tick(0, 1, 1, 1, 0, 1500, 2000, -100, 0, 20000, 320, 500);
        rows.push_back(rw);
        rw.t = mk_tick(0, 1, 1, 1, 0, 1500, 20000, -100, 0, 20000, 340, 3000);
        rows.push_back(rw);
        rw.t = mk_tick(0, 1, 1, 1, 0, 1500, 300, -50, 0, 20000, 360, 3000);
        rows.push_back(rw);
        rw.t = mk_tick(0, 1, 1, 1, 0, 1500, 300, -50, 0, 20000, 380, 3000);
        rows.push_back(rw);
        // land-hold above and below the safe height
        rw.t = mk_tick(0, 1, 1, 0, 0, 1500, 3000, 0, 100, 20000, 400, 0); rows.push_back(rw);
        rw.t = mk_tick(0, 1, 1, 0, 0, 1500, 100, 0, -100, 20000, 420, 0); rows.push_back(rw);
        // disarm: deactivation clamps
        rw.t = mk_tick(1, 0, 0, 0, 0, 1500, 100, 0, 0, 20000, 440, 0); rows.push_back(rw);

        foreach (rows[k])
            send_tick(rows[k].t, rows[k].lit, rows[k].r);

        // --- random segments, one register set each ---
        clock_ms = 1000;
        prof = FL_NOISE;
        prof_left = 0;
        est_c = 0;
        for (seg = 0; seg < 6; seg++) begin
            drain();
            case (seg)
                0: reg_write_all(srange(0, 255), srange(0, 255), srange(0, 255),
                                 srange(0, 255), srange(0, 255), srange(1000, 2000),
                                 srange(1000, 1400), srange(1600, 2000));
                1: reg_write_all(0, 0, 0, 0, 0, 1000, 1000, 1000);
                2: reg_write_all(255, 255, 255, 255, 255, 2000, 2000, 2000);
                // floor above ceiling
                3: reg_write_all(srange(0, 255), srange(0, 255), srange(0, 255),
                                 srange(0, 255), srange(0, 255), srange(1000, 2000),
                                 srange(1600, 2000), srange(1000, 1400));
                4: reg_write_all(srange(0, 255), srange(0, 255), srange(0, 255),
                                 srange(0, 255), srange(0, 255), srange(1000, 2000),
                                 srange(1000, 2000), srange(1000, 2000));
                default: reg_write_all(50, 100, 50, 10, 70, 1500, 1100, 1900);
            endcase
            // idling plan: sender-light, then receiver-light, then none
            if (seg < 2) begin
                snd_idle_pct = 15; rcv_idle_pct = 73;
            end else if (seg < 4) begin
                snd_idle_pct = 73; rcv_idle_pct = 15;
            end else begin
                snd_idle_pct = 0; rcv_idle_pct = 0;
            end

            for (n = 0; n < SEG_ITEMS; n++) begin
                if (prof_left == 0) begin
                    i = $urandom_range(99);
                    prof = i < 20 ? FL_SIT : i < 35 ? FL_CLIMB : i < 50 ? FL_HOVER :
                           i < 65 ? FL_GPS : i < 80 ? FL_LANDHOLD : FL_NOISE;
                    // occasional long sit so the landed timer runs out
                    prof_left = (prof == FL_SIT && $urandom_range(5) == 0) ?
                                srange(205, 230) : srange(3, 25);
                    est_c = srange(-300, 3000);
                end
                prof_left--;
                clock_ms += 20 + ($urandom_range(9) == 0 ? $urandom_range(40) : 0);
                case (prof)
                    FL_SIT:
                        t = mk_tick(1, 0, $urandom_range(49) != 0, 0, 1, srange(1000, 1100),
                                    srange(-40, 40), srange(-14, 14), srange(-300, 300),
                                    srange(15000, 25000), clock_ms, srange(-500, 500));
                    FL_CLIMB:
                        t = mk_tick(1, 0, 1, 0, $urandom_range(1), srange(1550, 2000),
                                    srange(0, 5000), srange(-50, 400), srange(-3000, 3000),
                                    srange(15000, 25000), clock_ms, 0);
                    FL_HOVER:
                        t = mk_tick(1, $urandom_range(9) == 0, 1, 0, $urandom_range(1),
                                    srange(1440, 1560), est_c + srange(-80, 80),
                                    srange(-60, 60), srange(-2000, 2000),
                                    srange(15000, 25000), clock_ms, 0);
                    FL_GPS:
                        t = mk_tick($urandom_range(1), 1, 1, 1, 0, srange(1000, 2000),
                                    $urandom_range(3) == 0 ? srange(0, 600)
                                                           : srange(0, 20000),
                                    srange(-400, 0), srange(-2000, 2000),
                                    srange(15000, 25000), clock_ms,
                                    $urandom_range(3) == 0 ? 500 : srange(-2000, 20000));
                    FL_LANDHOLD:
                        t = mk_tick($urandom_range(1), 1, $urandom_range(29) != 0, 0,
                                    $urandom_range(1), srange(1000, 2000),
                                    est_c + srange(-200, 200), srange(-30, 30),
                                    srange(-2000, 2000), srange(15000, 25000), clock_ms, 0);
                    default:
                        t = mk_tick($urandom_range(1), $urandom_range(1), $urandom_range(1),
                                    $urandom_range(1), $urandom_range(1), srange(1000, 2000),
                                    srange(-100000, 100000), srange(-5000, 5000),
                                    srange(-32768, 32767), $urandom_range(65535),
                                    $urandom, srange(-100000, 100000));
                endcase
                send_tick(t, 0, zero_res);
                // now and then let the pipe run dry mid-segment
                if ($urandom_range(199) == 0)
                    drain();
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
